// ----- src/assert_macros.svh -----
// Assertion shorthands shared by the controller RTL.
// Include with the bare file name; each macro expands to one labeled property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pid_pkg.sv -----
// Shared types and constants for the PID controller step block.
// No dependencies; imported by pid_cfg, pid_calc, the top level and the testbench.
`default_nettype none

package pid_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FILTER_SHIFT   = 2;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int ACC_W      = 32;
  localparam int SLOPE_W    = 18;
  localparam int COUNT_W    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 3'd7;
  localparam logic [COUNT_W-1:0] SETTLE_LIMIT = 3'd4;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_FEED_FORWARD  = 3'd3,
    REG_DRIVE_MAX     = 3'd4,
    REG_DRIVE_MIN     = 3'd5,
    REG_INTEGRAL_ZONE = 3'd6,
    REG_SETTLE_BAND   = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] GAIN_P_RST        = 16'h0100;
  localparam logic [CFG_W-1:0] GAIN_I_RST        = 16'h0000;
  localparam logic [CFG_W-1:0] GAIN_D_RST        = 16'h0000;
  localparam logic [CFG_W-1:0] FEED_FORWARD_RST  = 16'h0000;
  localparam logic [CFG_W-1:0] DRIVE_MAX_RST     = 16'h7fff;
  localparam logic [CFG_W-1:0] DRIVE_MIN_RST     = 16'h8000;
  localparam logic [CFG_W-1:0] INTEGRAL_ZONE_RST = 16'hffff;
  localparam logic [CFG_W-1:0] SETTLE_BAND_RST   = 16'h0000;

  // Gains and clamps are two's complement, zone and band are unsigned.
  typedef struct packed {
    logic [CFG_W-1:0] gain_p;
    logic [CFG_W-1:0] gain_i;
    logic [CFG_W-1:0] gain_d;
    logic [CFG_W-1:0] feed_forward;
    logic [CFG_W-1:0] drive_max;
    logic [CFG_W-1:0] drive_min;
    logic [CFG_W-1:0] integral_zone;
    logic [CFG_W-1:0] settle_band;
  } cfg_t;

  // Member order puts drive in the lowest bits, matching the output tdata layout.
  typedef struct packed {
    logic [ACC_W-1:0] integral_out;
    logic             settled;
    logic [CFG_W-1:0] drive;
  } result_t;

endpackage

`default_nettype wire

// ----- src/pid_controller_step_top.sv -----
// Top level of the PID controller step block: stream ports, input and result
// registers, controller state. Depends on pid_pkg, pid_cfg, pid_calc, assert_macros.svh.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: cmd; tdata: measured, setpoint
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: drive, settled, integral_out
//  cfg       | in        | cfg_we, no back-pressure    | cfg_addr, cfg_wdata
//
// Flow: one transfer per clock sustained while m_axis_tready stays high; a step passes the
//   input register, then the result register, on its way to m_axis. The step itself is one
//   pass of three parallel multipliers, an adder tree, the clamp and the integral update, and
//   the state loop through that pass sets the clock.
// Reset: rst is synchronous; it empties both registers, zeroes the controller state and
//   loads the configuration defaults.
// Stalls: while m_axis is held, one more item is taken into the input register, then
//   s_axis_tready drops until the result register frees up.
`default_nettype none
`include "assert_macros.svh"

module pid_controller_step_top #(
  parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low bit up: measured[DATA_WIDTH], setpoint[DATA_WIDTH], zero pad to bytes
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: cmd (0 control step, 1 clear state)
  input  logic                           s_axis_tuser,
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, low bit up: drive[16], settled[1], integral_out[32], zero pad [7]
  output logic [55:0]                    m_axis_tdata,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [pid_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pid_pkg::CFG_W-1:0]      cfg_wdata
);
  import pid_pkg::*;

  localparam int EW = DATA_WIDTH + 1;

  cfg_t                cfg;

  // input register
  logic                in_valid;
  logic                in_cmd;
  logic [DATA_WIDTH-1:0] in_measured;
  logic [DATA_WIDTH-1:0] in_setpoint;

  // result register
  logic                out_valid;
  result_t             out_res;

  // controller state
  logic [ACC_W-1:0]    integral_acc;
  logic [EW-1:0]       prior_error;
  logic [SLOPE_W-1:0]  filtered_slope;
  logic [COUNT_W-1:0]  settle_count;
  logic                settled_flag;

  logic [ACC_W-1:0]    integral_acc_next;
  logic [EW-1:0]       prior_error_next;
  logic [SLOPE_W-1:0]  filtered_slope_next;
  logic [COUNT_W-1:0]  settle_count_next;
  logic                settled_flag_next;
  result_t             res_next;

  logic                s_xfer;
  logic                advance;

  // Advance the held item into the result register when that register is free or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res};

  pid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pid_calc #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_calc (
    .cfg                 (cfg),
    .cmd                 (in_cmd),
    .measured            (in_measured),
    .setpoint            (in_setpoint),
    .integral_acc        (integral_acc),
    .prior_error         (prior_error),
    .filtered_slope      (filtered_slope),
    .settle_count        (settle_count),
    .settled_flag        (settled_flag),
    .integral_acc_next   (integral_acc_next),
    .prior_error_next    (prior_error_next),
    .filtered_slope_next (filtered_slope_next),
    .settle_count_next   (settle_count_next),
    .settled_flag_next   (settled_flag_next),
    .res                 (res_next)
  );

  // Input register: load on every slave transfer, drop once advanced.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_cmd      <= s_axis_tuser;
      in_measured <= s_axis_tdata[DATA_WIDTH-1:0];
      in_setpoint <= s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    end
  end

  // Result register: hold until the master side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  // State commits exactly once per step, when its result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc   <= '0;
      prior_error    <= '0;
      filtered_slope <= '0;
      settle_count   <= '0;
      settled_flag   <= 1'b0;
    end else if (advance) begin
      integral_acc   <= integral_acc_next;
      prior_error    <= prior_error_next;
      filtered_slope <= filtered_slope_next;
      settle_count   <= settle_count_next;
      settled_flag   <= settled_flag_next;
    end
  end

  `ASSERT_NEXT(a_clear_zero, clk, rst, advance && (in_cmd == CMD_CLEAR), m_axis_tvalid && (out_res == '0), "clear step did not give a zero result")
  `ASSERT_NEXT(a_settled_sticky, clk, rst, settled_flag && !(advance && (in_cmd == CMD_CLEAR)), settled_flag, "settled flag dropped without a clear")
  `ASSERT_IMPL(a_ready_low_full, clk, rst, !s_axis_tready, in_valid && out_valid && !m_axis_tready, "input stalled with room in the pipeline")
  `ASSERT_NEXT(a_drive_bounds, clk, rst, advance && (in_cmd == CMD_STEP) && ($signed(cfg.drive_min) <= $signed(cfg.drive_max)), ($signed(out_res.drive) <= $signed($past(cfg.drive_max))) && ($signed(out_res.drive) >= $signed($past(cfg.drive_min))), "drive outside clamp range")
  `ASSERT_NEXT(a_state_hold, clk, rst, !advance, $stable(integral_acc) && $stable(filtered_slope) && $stable(prior_error), "state changed without a step")

endmodule

`default_nettype wire

// ----- src/pid_cfg.sv -----
// Configuration register file for the PID controller step block.
// Depends on pid_pkg for the register map and reset values.
`default_nettype none

module pid_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pid_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pid_pkg::CFG_W-1:0]    cfg_wdata,
  output pid_pkg::cfg_t                cfg
);
  import pid_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= GAIN_P_RST;
      cfg.gain_i        <= GAIN_I_RST;
      cfg.gain_d        <= GAIN_D_RST;
      cfg.feed_forward  <= FEED_FORWARD_RST;
      cfg.drive_max     <= DRIVE_MAX_RST;
      cfg.drive_min     <= DRIVE_MIN_RST;
      cfg.integral_zone <= INTEGRAL_ZONE_RST;
      cfg.settle_band   <= SETTLE_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN_P:        cfg.gain_p        <= cfg_wdata;
        REG_GAIN_I:        cfg.gain_i        <= cfg_wdata;
        REG_GAIN_D:        cfg.gain_d        <= cfg_wdata;
        REG_FEED_FORWARD:  cfg.feed_forward  <= cfg_wdata;
        REG_DRIVE_MAX:     cfg.drive_max     <= cfg_wdata;
        REG_DRIVE_MIN:     cfg.drive_min     <= cfg_wdata;
        REG_INTEGRAL_ZONE: cfg.integral_zone <= cfg_wdata;
        REG_SETTLE_BAND:   cfg.settle_band   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/pid_calc.sv -----
// Single-pass PID step datapath: error, derivative filter, weighted sum,
// clamp, integral and settle updates. Pure combinational; depends on pid_pkg.
`default_nettype none

module pid_calc #(
  parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF
) (
  input  pid_pkg::cfg_t                cfg,
  input  logic                         cmd,
  input  logic [DATA_WIDTH-1:0]        measured,
  input  logic [DATA_WIDTH-1:0]        setpoint,
  input  logic [pid_pkg::ACC_W-1:0]    integral_acc,
  input  logic [DATA_WIDTH:0]          prior_error,
  input  logic [pid_pkg::SLOPE_W-1:0]  filtered_slope,
  input  logic [pid_pkg::COUNT_W-1:0]  settle_count,
  input  logic                         settled_flag,
  output logic [pid_pkg::ACC_W-1:0]    integral_acc_next,
  output logic [DATA_WIDTH:0]          prior_error_next,
  output logic [pid_pkg::SLOPE_W-1:0]  filtered_slope_next,
  output logic [pid_pkg::COUNT_W-1:0]  settle_count_next,
  output logic                         settled_flag_next,
  output pid_pkg::result_t             res
);
  import pid_pkg::*;

  localparam int EW  = DATA_WIDTH + 1;
  localparam int DW2 = EW + 1;
  localparam int AW  = (EW > CFG_W) ? EW : CFG_W;
  localparam int TW  = ((DW2 > SLOPE_W) ? DW2 : SLOPE_W) + 1;
  localparam int UW  = TW + 1;
  localparam int PPW = EW + CFG_W;
  localparam int PIW = ACC_W + CFG_W;
  localparam int PDW = SLOPE_W + CFG_W;
  localparam int SW  = ((PPW > PIW) ? PPW : PIW) + 2;
  localparam int DV  = SW + 1;
  localparam int IW  = ((EW > ACC_W) ? EW : ACC_W) + 1;

  logic signed [EW-1:0]      err;
  logic signed [EW-1:0]      prev;
  logic        [EW-1:0]      aerr;
  logic                      in_band;
  logic                      in_zone;
  logic        [COUNT_W-1:0] count_upd;

  logic signed [DW2-1:0]     diff;
  logic signed [SLOPE_W-1:0] slope_cur;
  logic signed [TW-1:0]      gap;
  logic signed [TW-1:0]      slope_inc;
  logic signed [UW-1:0]      slope_sum;
  logic        [UW-SLOPE_W:0] slope_top;
  logic signed [SLOPE_W-1:0] slope_new;

  logic signed [CFG_W-1:0]   kp, ki, kd, ff, dmax, dmin;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PPW-1:0]     p_p;
  logic signed [PIW-1:0]     p_i;
  logic signed [PDW-1:0]     p_d;
  logic signed [SW-1:0]      wsum;
  logic signed [SW-1:0]      scaled;
  logic signed [DV-1:0]      drv;
  logic                      over_hi;
  logic                      under_lo;
  logic        [CFG_W-1:0]   drive_cl;

  logic signed [IW-1:0]      acc_sum;
  logic        [IW-ACC_W:0]  acc_top;
  logic        [ACC_W-1:0]   acc_sat;
  logic        [ACC_W-1:0]   acc_upd;

  assign kp   = $signed(cfg.gain_p);
  assign ki   = $signed(cfg.gain_i);
  assign kd   = $signed(cfg.gain_d);
  assign ff   = $signed(cfg.feed_forward);
  assign dmax = $signed(cfg.drive_max);
  assign dmin = $signed(cfg.drive_min);
  assign acc  = $signed(integral_acc);

  // Error and its magnitude; |err| of the most negative value still fits in EW bits.
  assign err  = $signed({setpoint[DATA_WIDTH-1], setpoint})
              - $signed({measured[DATA_WIDTH-1], measured});
  assign prev = $signed(prior_error);
  assign aerr = err[EW-1] ? $unsigned(-err) : $unsigned(err);

  assign in_band = AW'(aerr) <= AW'(cfg.settle_band);
  assign in_zone = AW'(aerr) <  AW'(cfg.integral_zone);

  assign count_upd = !in_band                   ? '0 :
                     (settle_count == COUNT_MAX) ? settle_count :
                                                   settle_count + 3'd1;

  // First-order low-pass on the per-step error difference, saturated to the slope width.
  assign diff      = DW2'(err) - DW2'(prev);
  assign slope_cur = $signed(filtered_slope);
  assign gap       = TW'(diff) - TW'(slope_cur);
  assign slope_inc = gap >>> FILTER_SHIFT;
  assign slope_sum = UW'(slope_cur) + UW'(slope_inc);
  assign slope_top = slope_sum[UW-1:SLOPE_W-1];
  assign slope_new = ((&slope_top) || !(|slope_top)) ? slope_sum[SLOPE_W-1:0] :
                     {slope_sum[UW-1], {(SLOPE_W-1){~slope_sum[UW-1]}}};

  // Three products in parallel, one adder tree, then floor scaling.
  assign p_p    = PPW'(err) * PPW'(kp);
  assign p_i    = PIW'(acc) * PIW'(ki);
  assign p_d    = PDW'(slope_new) * PDW'(kd);
  assign wsum   = SW'(p_p) + SW'(p_i) + SW'(p_d);
  assign scaled = wsum >>> GAIN_FRAC_BITS;
  assign drv    = DV'(scaled) + DV'(ff);

  // Upper clamp has priority over the lower one.
  assign over_hi  = drv > DV'(dmax);
  assign under_lo = drv < DV'(dmin);
  assign drive_cl = over_hi  ? cfg.drive_max :
                    under_lo ? cfg.drive_min : drv[CFG_W-1:0];

  assign acc_sum = IW'(acc) + IW'(err);
  assign acc_top = acc_sum[IW-1:ACC_W-1];
  assign acc_sat = ((&acc_top) || !(|acc_top)) ? acc_sum[ACC_W-1:0] :
                   {acc_sum[IW-1], {(ACC_W-1){~acc_sum[IW-1]}}};

  // Anti-windup: hold the integral on a clamped step.
  assign acc_upd = (over_hi || under_lo) ? integral_acc :
                   in_zone               ? acc_sat : '0;

  always_comb begin
    if (cmd == CMD_CLEAR) begin
      integral_acc_next   = '0;
      prior_error_next    = '0;
      filtered_slope_next = '0;
      settle_count_next   = '0;
      settled_flag_next   = 1'b0;
      res                 = '0;
    end else begin
      integral_acc_next   = acc_upd;
      prior_error_next    = $unsigned(err);
      filtered_slope_next = $unsigned(slope_new);
      settle_count_next   = count_upd;
      settled_flag_next   = settled_flag || (count_upd > SETTLE_LIMIT);
      res.drive           = drive_cl;
      res.settled         = settled_flag || (count_upd > SETTLE_LIMIT);
      res.integral_out    = acc_upd;
    end
  end

endmodule

`default_nettype wire

// ----- tb/pid_controller_step_top_tb.sv -----
// Self-checking testbench for the PID controller step block: stream stimulus, bit-exact
// prediction of drive, settled flag and integral, checked in order on the result stream.
// Depends on pid_pkg and pid_controller_step_top; reads no files.
module pid_controller_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_pkg::*;

  localparam int    QUIET_LIMIT  = 3000;  // cycles with no transfer or register write before giving up
  localparam int    PIPE_SETTLE  = 4;     // cycles of settling after the drain, before a write
  localparam int    WINDUP_UP    = 40;    // steps with a large positive error
  localparam int    WINDUP_DOWN  = 80;    // steps with a large negative error
  localparam longint ACC_MAX     = 64'sd2147483647;
  localparam longint ACC_MIN     = -ACC_MAX - 1;
  localparam longint SLOPE_MAX   = (64'sd1 <<< (SLOPE_W - 1)) - 1;
  localparam longint SLOPE_MIN   = -SLOPE_MAX - 1;

  typedef struct {
    logic        cmd;
    logic [15:0] measured;
    logic [15:0] setpoint;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  pid_controller_step_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Controller mirror: configuration as last written, and the state as of the last s_axis
  // transfer, ahead of the block's result register. The state is updated only on a transfer.
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_val [8];
  longint           integ_acc  = 0;
  longint           last_err   = 0;
  longint           err_slope  = 0;
  logic [COUNT_W-1:0] settle_cnt = '0;
  logic             settled_now = 1'b0;

  sample_t          pending_q [$];   // steps waiting to go out on s_axis
  result_t          step_results_q [$];  // predicted results, oldest first
  int               mismatch_count = 0;

  function automatic longint as_s16(logic [15:0] v);
    logic signed [15:0] sv;
    sv = v;
    return longint'(sv);
  endfunction

  // One control step (or a clear): error, settle count, filtered slope, weighted sum, clamp, anti-windup update.
  function automatic result_t predict_pid_step(sample_t s);
    result_t r;
    longint  err, aerr, diff, sum, drv;
    longint  dmax, dmin, zone, band;
    r = '0;
    if (s.cmd == CMD_CLEAR) begin
      integ_acc = 0; last_err = 0; err_slope = 0;
      settle_cnt = '0; settled_now = 1'b0;
      return r;
    end
    zone = longint'(cfg_val[REG_INTEGRAL_ZONE]);
    band = longint'(cfg_val[REG_SETTLE_BAND]);
    dmax = as_s16(cfg_val[REG_DRIVE_MAX]);
    dmin = as_s16(cfg_val[REG_DRIVE_MIN]);

    err  = as_s16(s.setpoint) - as_s16(s.measured);
    aerr = (err < 0) ? -err : err;

    // Settle detection: saturating run count, sticky flag past the limit.
    if (aerr <= band) begin
      if (settle_cnt < COUNT_MAX) settle_cnt = settle_cnt + 1'b1;
      if (settle_cnt > SETTLE_LIMIT) settled_now = 1'b1;
    end else begin
      settle_cnt = '0;
    end

    // First-order low-pass on the per-step error difference; new slope used right away.
    diff      = err - last_err;
    err_slope = err_slope + ((diff - err_slope) >>> FILTER_SHIFT);
    if (err_slope > SLOPE_MAX) err_slope = SLOPE_MAX;
    if (err_slope < SLOPE_MIN) err_slope = SLOPE_MIN;
    last_err  = err;

    sum = err * as_s16(cfg_val[REG_GAIN_P]) + integ_acc * as_s16(cfg_val[REG_GAIN_I])
        + err_slope * as_s16(cfg_val[REG_GAIN_D]);
    drv = (sum >>> GAIN_FRAC_BITS) + as_s16(cfg_val[REG_FEED_FORWARD]);

    // Upper clamp wins when the limits cross; integral moves only on unclamped steps.
    if (drv > dmax) begin
      drv = dmax;
    end else if (drv < dmin) begin
      drv = dmin;
    end else if (aerr < zone) begin
      integ_acc = integ_acc + err;
      if (integ_acc > ACC_MAX) integ_acc = ACC_MAX;
      if (integ_acc < ACC_MIN) integ_acc = ACC_MIN;
    end else begin
      integ_acc = 0;
    end

    r.drive        = drv[15:0];
    r.settled      = settled_now;
    r.integral_out = integ_acc[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, and a rare hold until the result stream
  // has drained completely. tvalid is computed once per edge and assigned once.
  // ---------------------------------------------------------------------------------------
  sample_t on_bus;
  int      burst_left = 0;
  int      gap_left   = 0;
  bit      drain_hold = 1'b0;

  always @(posedge clk) begin
    logic present;
    present = s_axis_tvalid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_results_q.push_back(predict_pid_step(on_bus));
        present = 1'b0;
      end
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (drain_hold) begin
          if (step_results_q.size() == 0) drain_hold = 1'b0;
        end else if (pending_q.size() > 0) begin
          on_bus  = pending_q.pop_front();
          present = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(10, 30);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end else begin
            burst_left--;
          end
          if ($urandom_range(0, 299) == 0) drain_hold = 1'b1;
        end
      end
      s_axis_tvalid <= present;
      s_axis_tdata  <= {on_bus.setpoint, on_bus.measured};
      s_axis_tuser  <= on_bus.cmd;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: switch every so often between always ready, coin-flip ready, and mostly ready
  // with occasional long stalls.
  // ---------------------------------------------------------------------------------------
  int tready_mode  = 0;
  int mode_cycles  = 0;
  int stall_cycles = 0;

  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_cycles > 0) begin
        stall_cycles--;
        rdy = 1'b0;
      end else begin
        case (tready_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_cycles = $urandom_range(1, 24);
              rdy = 1'b0;
            end
          end
        endcase
      end
      if (mode_cycles == 0) begin
        tready_mode = $urandom_range(0, 2);
        mode_cycles = $urandom_range(20, 200);
      end else begin
        mode_cycles--;
      end
      m_axis_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result checker: every m_axis transfer against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (step_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got drive %0d settled %0b integral %0d",
                 $time, $signed(got.drive), got.settled, $signed(got.integral_out));
        mismatch_count++;
      end else begin
        want = step_results_q.pop_front();
        if (got.drive !== want.drive) begin
          $display("%0t: drive mismatch, expected %0d, got %0d",
                   $time, $signed(want.drive), $signed(got.drive));
          mismatch_count++;
        end
        if (got.settled !== want.settled) begin
          $display("%0t: settled mismatch, expected %0b, got %0b",
                   $time, want.settled, got.settled);
          mismatch_count++;
        end
        if (got.integral_out !== want.integral_out) begin
          $display("%0t: integral mismatch, expected %0d, got %0d",
                   $time, $signed(want.integral_out), $signed(got.integral_out));
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pid_controller_step_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------------------
  function automatic void queue_item(logic cmd, int ms, int sp);
    sample_t s;
    s.cmd      = cmd;
    s.measured = ms[15:0];
    s.setpoint = sp[15:0];
    pending_q.push_back(s);
  endfunction

  // Closed-loop-like run: measured halves its distance to a fixed target, with optional
  // noise, so settle runs and integral buildup both happen.
  function automatic void queue_tracking(int n);
    int sp, ms, nz, span;
    sp = int'($urandom_range(0, 65535)) - 32768;
    ms = int'($urandom_range(0, 65535)) - 32768;
    nz = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 64));
    for (int k = 0; k < n; k++) begin
      span = sp - ms;
      if (span >= -1 && span <= 1) ms = sp;
      else ms = ms + span / 2;
      if (nz != 0) ms = ms + int'($urandom_range(0, 2 * nz)) - nz;
      if (ms > 32767) ms = 32767;
      if (ms < -32768) ms = -32768;
      queue_item(CMD_STEP, ms, sp);
    end
  endfunction

  function automatic void queue_random_mix(int n);
    int made, len, pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(5, 30);
        queue_tracking(len);
      end else if (pick < 92) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          queue_item($urandom_range(0, 9) == 0, $urandom, $urandom);
      end else begin
        len = 1;
        queue_item(CMD_CLEAR, $urandom, $urandom);
      end
      made += len;
    end
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    int   m;
    c.gain_p       = pick_gain();
    c.gain_i       = pick_gain();
    c.gain_d       = pick_gain();
    c.feed_forward = ($urandom_range(0, 1) == 0) ? 16'h0000 : pick_gain();
    case ($urandom_range(0, 3))
      0: begin c.drive_max = DRIVE_MAX_RST;   c.drive_min = DRIVE_MIN_RST; end
      1: begin c.drive_max = 16'($urandom);   c.drive_min = 16'($urandom); end
      2: begin
        m = $urandom_range(0, 20000);
        c.drive_max = 16'(m);
        c.drive_min = 16'(-m);
      end
      default: begin  // crossed limits
        m = $urandom_range(1, 5000);
        c.drive_max = 16'(-m);
        c.drive_min = 16'(m);
      end
    endcase
    case ($urandom_range(0, 3))
      0:       c.integral_zone = 16'h0000;
      1:       c.integral_zone = 16'hffff;
      2:       c.integral_zone = 16'($urandom_range(0, 2000));
      default: c.integral_zone = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       c.settle_band = 16'h0000;
      1:       c.settle_band = 16'hffff;
      2:       c.settle_band = 16'($urandom_range(0, 50));
      default: c.settle_band = 16'($urandom);
    endcase
    return c;
  endfunction

  // Register writes happen only with the pipe empty, so the mirror can follow at once.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_val[idx] = val;
  endtask

  task automatic load_settings(cfg_t c);
    write_reg(REG_GAIN_P,        c.gain_p);
    write_reg(REG_GAIN_I,        c.gain_i);
    write_reg(REG_GAIN_D,        c.gain_d);
    write_reg(REG_FEED_FORWARD,  c.feed_forward);
    write_reg(REG_DRIVE_MAX,     c.drive_max);
    write_reg(REG_DRIVE_MIN,     c.drive_min);
    write_reg(REG_INTEGRAL_ZONE, c.integral_zone);
    write_reg(REG_SETTLE_BAND,   c.settle_band);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued step went out and every result came back, then let the
  // two-stage pipe settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_q.size() != 0 || s_axis_tvalid || step_results_q.size() != 0);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    cfg_t c;
    cfg_val[REG_GAIN_P]        = GAIN_P_RST;
    cfg_val[REG_GAIN_I]        = GAIN_I_RST;
    cfg_val[REG_GAIN_D]        = GAIN_D_RST;
    cfg_val[REG_FEED_FORWARD]  = FEED_FORWARD_RST;
    cfg_val[REG_DRIVE_MAX]     = DRIVE_MAX_RST;
    cfg_val[REG_DRIVE_MIN]     = DRIVE_MIN_RST;
    cfg_val[REG_INTEGRAL_ZONE] = INTEGRAL_ZONE_RST;
    cfg_val[REG_SETTLE_BAND]   = SETTLE_BAND_RST;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: zero-error run sets the sticky flag on the fifth sample, full-scale
    // errors in both directions hit the clamps, clear ignores its data.
    repeat (6) queue_item(CMD_STEP, 0, 0);
    queue_item(CMD_STEP, -32768, 32767);
    queue_item(CMD_STEP, 32767, -32768);
    queue_item(CMD_STEP, 100, -100);
    queue_item(CMD_CLEAR, 32'hffff, 32'hffff);
    queue_item(CMD_STEP, 5, 5);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin  // every register at one extreme, band wide open
          c = '{gain_p: 16'h7fff, gain_i: 16'h8000, gain_d: 16'h7fff, feed_forward: 16'h8000,
                drive_max: 16'h7fff, drive_min: 16'h8000, integral_zone: 16'hffff,
                settle_band: 16'hffff};
        end
        1: begin  // the other extremes: crossed limits, zero zone and band
          c = '{gain_p: 16'h8000, gain_i: 16'h7fff, gain_d: 16'h8000, feed_forward: 16'h7fff,
                drive_max: 16'h8000, drive_min: 16'h7fff, integral_zone: 16'h0000,
                settle_band: 16'h0000};
        end
        2: begin  // moderate loop with tight zone and band
          c = '{gain_p: 16'd256, gain_i: 16'd16, gain_d: 16'd64, feed_forward: 16'd0,
                drive_max: 16'd30000, drive_min: -16'sd30000, integral_zone: 16'd500,
                settle_band: 16'd20};
        end
        default: c = random_settings();
      endcase
      load_settings(c);
      if (ph < 3) begin
        queue_item(CMD_STEP, 0, 0);
        queue_item(CMD_STEP, -32768, 32767);
        queue_item(CMD_STEP, 32767, -32768);
      end
      if (ph == 2) begin
        // zone boundary (equal clears) and band boundary (equal counts)
        queue_item(CMD_STEP, 0, 499);
        queue_item(CMD_STEP, 0, 500);
        queue_item(CMD_STEP, 0, -500);
        repeat (5) queue_item(CMD_STEP, 0, 20);
        queue_item(CMD_STEP, 0, 21);
      end
      queue_random_mix(100);
      wait_drained();
    end

    // Wind-up: with all gains zero the drive is just the offset, never clamped, so the
    // integral climbs on large positive errors and then swings well below zero.
    c = '{gain_p: 16'd0, gain_i: 16'd0, gain_d: 16'd0, feed_forward: 16'($urandom_range(0, 999)),
          drive_max: DRIVE_MAX_RST, drive_min: DRIVE_MIN_RST, integral_zone: 16'hffff,
          settle_band: 16'd0};
    load_settings(c);
    repeat (WINDUP_UP)
      queue_item(CMD_STEP, -32768 + int'($urandom_range(0, 300)),
                 32767 - int'($urandom_range(0, 200)));
    repeat (WINDUP_DOWN)
      queue_item(CMD_STEP, 32767 - int'($urandom_range(0, 300)),
                 -32768 + int'($urandom_range(0, 200)));
    queue_item(CMD_CLEAR, $urandom, $urandom);
    queue_random_mix(20);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && step_results_q.size() == 0) begin
      $display("pid_controller_step_top_tb passed");
    end else begin
      $display("pid_controller_step_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/pid_pkg.sv
src/pid_cfg.sv
src/pid_calc.sv
src/pid_controller_step_top.sv
tb/pid_controller_step_top_tb.sv
